// ===== hdl/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  // Widest cell index the CAPACITY range can need (4096 entries).
  localparam int unsigned IDX_W_MAX = 12;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_WRITE  = 3'd2;
  localparam logic [2:0] REQ_INSERT = 3'd3;
  localparam logic [2:0] REQ_DELETE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [9:0]          position;
    logic signed [31:0]  value_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  read_value;
    logic [1:0]          status;
    logic [6:0]          length;
  } out_t;

  // What every cell does this cycle.
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,  // cell at idx takes the value
    OP_SHR   = 2'd2,  // open a gap at idx, take the value there
    OP_SHL   = 2'd3   // close the gap at idx
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [IDX_W_MAX-1:0]   idx;
    logic signed [31:0]     value;
  } cell_ctl_t;

endpackage

// ===== hdl/ple_cell.sv =====
// One list slot: holds an entry and trades it with its neighbors.
module ple_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                   clk_i,
  input  ple_pkg::cell_ctl_t     ctl_i,
  input  logic signed [31:0]     left_i,
  input  logic signed [31:0]     right_i,
  output logic signed [31:0]     value_o,
  output logic signed [31:0]     rd_o
);

  localparam logic [ple_pkg::IDX_W_MAX-1:0] MyIdx = ple_pkg::IDX_W_MAX'(IDX);

  logic signed [31:0] value_q, value_d;
  logic               hit, above;

  assign hit   = (ctl_i.idx == MyIdx);
  assign above = (MyIdx > ctl_i.idx);

  always_comb begin
    value_d = value_q;
    case (ctl_i.op)
      ple_pkg::OP_LOAD: begin
        if (hit) value_d = ctl_i.value;
      end
      ple_pkg::OP_SHR: begin
        if (hit) value_d = ctl_i.value;
        else if (above) value_d = left_i;
      end
      ple_pkg::OP_SHL: begin
        if (hit || above) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // One-hot read bus: only the selected slot drives nonzero.
  assign rd_o    = hit ? value_q : 32'sd0;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Top level of the positional list engine: decode, entry count, cell row, result register.
//
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells, one entry
// per cell. Append, read, write, insert and delete act on the row when accepted; insert
// and delete move every later entry by one slot in the same cycle, each cell loading
// from its neighbor. One request is accepted per cycle while the result register is empty
// or being drained; the result appears in the cycle after acceptance. Reads select the
// entry through a one-hot OR bus across the row. No clearing pass is needed after reset.
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ple_pkg::in_t  in_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output ple_pkg::out_t out_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = (CW > 10) ? CW : 10;

  logic [CW-1:0]        count_q, count_d;
  ple_pkg::out_t        out_q, out_d;
  logic                 out_valid_q;
  logic                 acc;
  ple_pkg::cell_ctl_t   ctl;
  logic [9:0]           idx_raw;
  logic [WW-1:0]        idx_w, n_w;
  logic                 full, empty, read_en;
  logic [1:0]           status;
  logic signed [31:0]   rd_or;

  logic signed [31:0]   cell_val [CAPACITY];
  logic signed [31:0]   cell_rd  [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign idx_raw = (in_i.position <= 10'd1) ? 10'd0 : in_i.position - 10'd1;
  assign idx_w   = WW'(idx_raw);
  assign n_w     = WW'(count_q);
  assign full    = (n_w == WW'(CAPACITY));
  assign empty   = (count_q == '0);

  always_comb begin
    ctl.op    = ple_pkg::OP_HOLD;
    ctl.idx   = '0;
    ctl.value = in_i.value_in;
    status    = ple_pkg::ST_OK;
    count_d   = count_q;
    read_en   = 1'b0;
    case (in_i.req_type)
      ple_pkg::REQ_APPEND: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          ctl.op  = ple_pkg::OP_SHR;
          ctl.idx = ple_pkg::IDX_W_MAX'(count_q);
          count_d = count_q + 1'b1;
        end
      end
      ple_pkg::REQ_READ, ple_pkg::REQ_WRITE: begin
        if (empty) begin
          status = ple_pkg::ST_EMPTY;
        end else begin
          ctl.idx = (idx_w >= n_w) ? ple_pkg::IDX_W_MAX'(count_q - 1'b1)
                                   : ple_pkg::IDX_W_MAX'(idx_w);
          if (in_i.req_type == ple_pkg::REQ_READ) read_en = 1'b1;
          else ctl.op = ple_pkg::OP_LOAD;
        end
      end
      ple_pkg::REQ_INSERT: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          ctl.op  = ple_pkg::OP_SHR;
          ctl.idx = (idx_w > n_w) ? ple_pkg::IDX_W_MAX'(count_q)
                                  : ple_pkg::IDX_W_MAX'(idx_w);
          count_d = count_q + 1'b1;
        end
      end
      ple_pkg::REQ_DELETE: begin
        if (empty) begin
          status = ple_pkg::ST_EMPTY;
        end else if (idx_w >= n_w) begin
          status = ple_pkg::ST_RANGE;
        end else begin
          ctl.op  = ple_pkg::OP_SHL;
          ctl.idx = ple_pkg::IDX_W_MAX'(idx_w);
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        status = ple_pkg::ST_OK;
      end
    endcase
    if (!acc) begin
      ctl.op  = ple_pkg::OP_HOLD;
      count_d = count_q;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left, right;
    if (i == 0) begin : g_first
      assign left = 32'sd0;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_val[i];
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end
    ple_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_val[i]),
      .rd_o    (cell_rd[i])
    );
  end

  always_comb begin
    rd_or = 32'sd0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    out_d.read_value = read_en ? rd_or : 32'sd0;
    out_d.status     = status;
    out_d.length     = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (acc) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) out_q <= out_d;
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_w <= WW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted request left no result");

  a_full_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && full && in_i.req_type == ple_pkg::REQ_APPEND
      |=> out_q.status == ple_pkg::ST_FULL && count_q == $past(count_q))
    else $error("append on full list not flagged");

  a_delete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && ctl.op == ple_pkg::OP_SHL |=> count_q == CW'($past(count_q) - 1'b1))
    else $error("delete did not shrink the list");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ple_pkg::ST_OK |-> out_q.read_value == 32'sd0)
    else $error("error result carries read data");

endmodule

// ===== tb/ple_result_checker.sv =====
// Request/result checker for the positional list engine: shadow list, expected-result queue, compare.
module ple_result_checker #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ple_pkg::in_t  req_i,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  ple_pkg::out_t res_i,
  input  logic          res_valid_i,
  input  logic          res_ready_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   pending_count_o,
  output int unsigned   checked_count_o,
  output int unsigned   empty_hits_o,
  output int unsigned   full_hits_o,
  output int unsigned   range_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  logic signed [31:0] shadow_entries [CAPACITY];
  int unsigned        shadow_len;
  out_t               expected_results [$];
  out_t               want;
  int unsigned        mismatches, checked, empty_hits, full_hits, range_hits;

  // Applies one request to the shadow list and returns the result it must produce.
  function automatic out_t apply_request(in_t req);
    out_t        r;
    int unsigned idx;
    r = '0;
    r.status = ST_OK;
    idx = (req.position <= 10'd1) ? 0 : int'(req.position) - 1;
    case (req.req_type)
      REQ_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_len] = req.value_in;
          shadow_len++;
        end
      end
      REQ_READ, REQ_WRITE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (idx >= shadow_len) idx = shadow_len - 1;
          if (req.req_type == REQ_READ) r.read_value = shadow_entries[idx];
          else shadow_entries[idx] = req.value_in;
        end
      end
      REQ_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (idx > shadow_len) idx = shadow_len;
          for (int unsigned i = shadow_len; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[idx] = req.value_in;
          shadow_len++;
        end
      end
      REQ_DELETE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (idx >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = idx; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_len--;
        end
      end
      default: ;  // reserved codes leave the list alone
    endcase
    r.length = shadow_len[6:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      shadow_len = 0;
      mismatches = 0;
      checked    = 0;
      empty_hits = 0;
      full_hits  = 0;
      range_hits = 0;
    end else begin
      // Result first: a result never belongs to a request accepted at the same edge.
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_value=%0d status=%0d length=%0d",
                   $realtime, res_i.read_value, res_i.status, res_i.length);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.read_value !== res_i.read_value) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $realtime, want.read_value, res_i.read_value);
            mismatches++;
          end
          if (want.status !== res_i.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, res_i.status);
            mismatches++;
          end
          if (want.length !== res_i.length) begin
            $display("%0t: length expected %0d actual %0d", $realtime, want.length, res_i.length);
            mismatches++;
          end
          case (want.status)
            ST_EMPTY: empty_hits++;
            ST_FULL:  full_hits++;
            ST_RANGE: range_hits++;
            default:  ;
          endcase
        end
      end
      if (req_valid_i && req_ready_i) expected_results.push_back(apply_request(req_i));
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= expected_results.size();
    checked_count_o  <= checked;
    empty_hits_o     <= empty_hits;
    full_hits_o      <= full_hits;
    range_hits_o     <= range_hits;
  end

endmodule

// ===== tb/tb.sv =====
// Top of the positional list engine testbench: clock, reset, request stimulus, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;
  localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] REQ_RESERVED_MID   = 3'd6;
  localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  logic clk;
  logic rst_n;
  in_t  req;
  logic req_valid;
  logic req_ready;
  out_t res;
  logic res_valid;
  logic res_ready;

  int unsigned mismatch_count, pending_count, checked_count;
  int unsigned empty_hits, full_hits, range_hits;
  int unsigned idle_pct, stall_pct, hold_off_left, requests_sent;

  positional_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (req),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .out_o       (res),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready)
  );

  ple_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_i            (req),
    .req_valid_i      (req_valid),
    .req_ready_i      (req_ready),
    .res_i            (res),
    .res_valid_i      (res_valid),
    .res_ready_i      (res_ready),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count),
    .empty_hits_o     (empty_hits),
    .full_hits_o      (full_hits),
    .range_hits_o     (range_hits)
  );

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    req           = '0;
    req_valid     = 1'b0;
    res_ready     = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_off_left = 0;
    requests_sent = 0;
  end

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        res_ready <= 1'b0;
        hold_off_left--;
      end else begin
        res_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Returns at the edge that accepts the request; valid stays up for the caller.
  task automatic send_request(logic [2:0] kind, logic [9:0] pos, logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= '{req_type: kind, position: pos, value_in: val};
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (kind < REQ_RESERVED_FIRST) requests_sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] rand_position(int unsigned span);
    case ($urandom_range(19))
      0, 1:    return 10'($urandom_range(1023));
      2:       return 10'd1023;
      3:       return 10'd0;
      default: return 10'($urandom_range(span));
    endcase
  endfunction

  // grow_pct: share of appends/inserts; shrink_pct: share of deletes; the rest read/write.
  task automatic run_segment(int unsigned count, int unsigned grow_pct, int unsigned shrink_pct,
                             int unsigned span);
    int unsigned done;
    int unsigned r;
    logic [2:0]  kind;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 2) begin
        kind = 3'($urandom_range(REQ_RESERVED_LAST, REQ_RESERVED_FIRST));
      end else begin
        r = $urandom_range(99);
        if (r < grow_pct) kind = $urandom_range(1) ? REQ_APPEND : REQ_INSERT;
        else if (r < grow_pct + shrink_pct) kind = REQ_DELETE;
        else kind = $urandom_range(1) ? REQ_READ : REQ_WRITE;
        done++;
      end
      send_request(kind, rand_position(span), rand_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list errors, reserved codes, head/tail/clamp handling, out-of-range delete.
    send_request(REQ_READ,           10'd1,    32'h0);
    send_request(REQ_WRITE,          10'd0,    32'h1);
    send_request(REQ_DELETE,         10'd0,    32'h0);
    send_request(REQ_RESERVED_FIRST, 10'd1,    32'h0);
    send_request(REQ_RESERVED_LAST,  10'd1023, 32'hffff_ffff);
    send_request(REQ_APPEND,         10'd0,    32'h7fff_ffff);
    send_request(REQ_APPEND,         10'd1023, 32'h8000_0000);
    send_request(REQ_INSERT,         10'd0,    32'hffff_ffff);
    send_request(REQ_INSERT,         10'd1023, 32'h0);
    send_request(REQ_INSERT,         10'd3,    32'h1234_5678);
    send_request(REQ_READ,           10'd0,    32'h0);
    send_request(REQ_READ,           10'd1023, 32'h0);
    send_request(REQ_READ,           10'd3,    32'h0);
    send_request(REQ_WRITE,          10'd1023, 32'h5555_5555);
    send_request(REQ_WRITE,          10'd2,    32'haaaa_aaaa);
    send_request(REQ_DELETE,         10'd1023, 32'h0);
    send_request(REQ_DELETE,         10'd0,    32'h0);
    send_request(REQ_DELETE,         10'd4,    32'h0);
    send_request(REQ_READ,           10'd2,    32'h0);
    send_request(REQ_INSERT,         10'd1,    32'h1);
    send_request(REQ_READ,           10'd1,    32'h0);
    send_request(REQ_RESERVED_MID,   10'd512,  32'h0);
    send_request(REQ_DELETE,         10'd1,    32'h0);
    send_request(REQ_DELETE,         10'd1,    32'h0);
    send_request(REQ_DELETE,         10'd1,    32'h0);

    // Random: each idle profile fills the list to full, mixes, then drains it to empty.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 75; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if (phase == 0) hold_off_left = HOLD_OFF_CYCLES;
      run_segment(100, 85, 5, CAPACITY + 6);
      run_segment(30, 35, 35, CAPACITY + 6);
      run_segment(85, 5, 85, 8);
    end

    req_valid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests, %0d results checked.", requests_sent, checked_count);
    $display("Errors seen: %0d empty-list, %0d full-list, %0d out-of-range.",
             empty_hits, full_hits, range_hits);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
